[hw/rtl/matrix3x3_inverse_unit_macros.svh]
// Assertion macros for the 3x3 matrix inverse unit.
`ifndef MATRIX3X3_INVERSE_UNIT_MACROS_SVH
`define MATRIX3X3_INVERSE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MX3I_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mx3i: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MX3I_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mx3i: next-cycle check failed");

`endif

[hw/rtl/mx3i_pkg.sv]
// Shared types and constants of the 3x3 matrix inverse unit.
`default_nettype none

package mx3i_pkg;

  localparam int unsigned ELEM_WIDTH = 32;
  localparam int unsigned NUM_ELEM   = 9;

  typedef struct packed {
    logic signed [ELEM_WIDTH-1:0] m11;
    logic signed [ELEM_WIDTH-1:0] m12;
    logic signed [ELEM_WIDTH-1:0] m13;
    logic signed [ELEM_WIDTH-1:0] m21;
    logic signed [ELEM_WIDTH-1:0] m22;
    logic signed [ELEM_WIDTH-1:0] m23;
    logic signed [ELEM_WIDTH-1:0] m31;
    logic signed [ELEM_WIDTH-1:0] m32;
    logic signed [ELEM_WIDTH-1:0] m33;
  } in_word_t;

  typedef struct packed {
    logic signed [ELEM_WIDTH-1:0] inv11;
    logic signed [ELEM_WIDTH-1:0] inv12;
    logic signed [ELEM_WIDTH-1:0] inv13;
    logic signed [ELEM_WIDTH-1:0] inv21;
    logic signed [ELEM_WIDTH-1:0] inv22;
    logic signed [ELEM_WIDTH-1:0] inv23;
    logic signed [ELEM_WIDTH-1:0] inv31;
    logic signed [ELEM_WIDTH-1:0] inv32;
    logic signed [ELEM_WIDTH-1:0] inv33;
    logic signed [ELEM_WIDTH-1:0] det_value;
    logic                         singular;
    logic                         saturated;
  } out_word_t;

  // Per-item status that rides along the divider stages.
  typedef struct packed {
    logic [NUM_ELEM-1:0]   neg;
    logic [NUM_ELEM-1:0]   ovf;
    logic                  sing;
    logic [ELEM_WIDTH-1:0] det_val;
    logic                  det_sat;
  } side_t;

endpackage

`default_nettype wire

[hw/rtl/mx3i_div_step.sv]
// One restoring-division step for all nine lanes, with shared divisor.
`default_nettype none

module mx3i_div_step #(
  parameter int unsigned RW    = 131,
  parameter int unsigned DW    = 99,
  parameter int unsigned QW    = 32,
  parameter int unsigned SHIFT = 0
) (
  input  wire logic                  clk_i,
  input  wire logic                  ld_i,
  input  wire logic [RW-1:0]         rem_i [mx3i_pkg::NUM_ELEM],
  input  wire logic [QW-1:0]         quo_i [mx3i_pkg::NUM_ELEM],
  input  wire logic [DW-1:0]         dvs_i,
  input  wire mx3i_pkg::side_t       side_i,
  output logic      [RW-1:0]         rem_o [mx3i_pkg::NUM_ELEM],
  output logic      [QW-1:0]         quo_o [mx3i_pkg::NUM_ELEM],
  output logic      [DW-1:0]         dvs_o,
  output mx3i_pkg::side_t            side_o
);

  logic [RW-1:0] sub_val;
  logic [RW:0]   trial [mx3i_pkg::NUM_ELEM];
  logic [RW-1:0] rem_d [mx3i_pkg::NUM_ELEM];
  logic [QW-1:0] quo_d [mx3i_pkg::NUM_ELEM];

  assign sub_val = RW'(dvs_i) << SHIFT;

  always_comb begin
    for (int l = 0; l < int'(mx3i_pkg::NUM_ELEM); l++) begin
      trial[l] = {1'b0, rem_i[l]} - {1'b0, sub_val};
      rem_d[l] = trial[l][RW] ? rem_i[l] : trial[l][RW-1:0];
      quo_d[l] = quo_i[l];
      quo_d[l][SHIFT] = !trial[l][RW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      rem_o  <= rem_d;
      quo_o  <= quo_d;
      dvs_o  <= dvs_i;
      side_o <= side_i;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/matrix3x3_inverse_unit.sv]
// 3x3 matrix inverse unit: the top level.
//
// Usage: one word on in_data_i carries a full 3x3 matrix of signed fixed-point
// elements (FRAC_BITS fraction bits); one word on out_data_o carries the nine
// inverse elements, the determinant and the singular and saturated flags.
// Both channels are valid/ready; a word moves when valid and ready are high.
// From acceptance a matrix passes through seven arithmetic stages (products,
// cofactors, split determinant products, their sum, magnitudes, range check),
// then one restoring-division step per quotient bit across all nine lanes,
// then the output register. Throughput is one matrix per cycle while
// out_ready_i does not stall the output.
// Each stage holds its word only while the stage after it is full and
// blocked, so empty slots close up when out_ready_i is low, and in_ready_o
// drops only once the whole pipeline is full behind a waiting result.
// Reset empties the pipeline; no word is pending afterwards.
// A zero determinant gives singular high, all outputs zero, saturated low.
`default_nettype none

module matrix3x3_inverse_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire mx3i_pkg::in_word_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output mx3i_pkg::out_word_t      out_data_o
);

`include "matrix3x3_inverse_unit_macros.svh"

  localparam int unsigned EW = mx3i_pkg::ELEM_WIDTH;
  localparam int unsigned NL = mx3i_pkg::NUM_ELEM;
  localparam int unsigned PW = 2 * EW;
  localparam int unsigned AW = PW + 1;
  localparam int unsigned LW = 2 * EW + 1;
  localparam int unsigned TW = EW + AW;
  localparam int unsigned DW = TW + 2;
  localparam int unsigned NW = AW + 2 * FRAC_BITS;
  localparam int unsigned RW = (NW > DW + EW) ? NW : DW + EW;
  localparam int unsigned NS = 7 + EW;

  // Operand indices x, y, z, v of each adjugate entry x*y - z*v, row-major.
  localparam int unsigned CofIdx [9][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  // ---------------- flow control ----------------
  logic [NS-1:0] v_q;
  logic [NS-1:0] v_d;
  logic [NS:0]   ld;
  logic          out_valid_q;

  assign ld[NS] = !out_valid_q || out_ready_i;
  for (genvar k = 0; k < NS; k++) begin : g_ld
    assign ld[k] = !v_q[k] || ld[k+1];
  end
  assign in_ready_o = ld[0];
  assign v_d = {v_q[NS-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      for (int k = 0; k < int'(NS); k++) begin
        if (ld[k]) v_q[k] <= v_d[k];
      end
      if (ld[NS]) out_valid_q <= v_q[NS-1];
    end
  end

  // ---------------- stage 0: pair products ----------------
  logic signed [EW-1:0] mm [NL];
  logic signed [PW-1:0] p_d [2*NL];
  logic signed [PW-1:0] p_q [2*NL];
  logic signed [EW-1:0] r0m_q [3];

  always_comb begin
    mm[0] = in_data_i.m11; mm[1] = in_data_i.m12; mm[2] = in_data_i.m13;
    mm[3] = in_data_i.m21; mm[4] = in_data_i.m22; mm[5] = in_data_i.m23;
    mm[6] = in_data_i.m31; mm[7] = in_data_i.m32; mm[8] = in_data_i.m33;
    for (int k = 0; k < int'(NL); k++) begin
      p_d[2*k]   = PW'(mm[CofIdx[k][0]]) * PW'(mm[CofIdx[k][1]]);
      p_d[2*k+1] = PW'(mm[CofIdx[k][2]]) * PW'(mm[CofIdx[k][3]]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      p_q      <= p_d;
      r0m_q[0] <= mm[0];
      r0m_q[1] <= mm[1];
      r0m_q[2] <= mm[2];
    end
  end

  // ---------------- stage 1: cofactors ----------------
  logic signed [AW-1:0] adj1_q [NL];
  logic signed [EW-1:0] r1m_q [3];

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      for (int k = 0; k < int'(NL); k++) begin
        adj1_q[k] <= AW'(p_q[2*k]) - AW'(p_q[2*k+1]);
      end
      r1m_q <= r0m_q;
    end
  end

  // ---------------- stage 2: split determinant products ----------------
  logic signed [LW-1:0] plo_q [3];
  logic signed [LW-1:0] phi_q [3];
  logic signed [AW-1:0] adj2_q [NL];

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      for (int j = 0; j < 3; j++) begin
        plo_q[j] <= LW'(r1m_q[j]) * LW'($signed({1'b0, adj1_q[3*j][EW-1:0]}));
        phi_q[j] <= LW'(r1m_q[j]) * LW'($signed(adj1_q[3*j][AW-1:EW]));
      end
      adj2_q <= adj1_q;
    end
  end

  // ---------------- stage 3: recombine partial products ----------------
  logic signed [DW-1:0] t_q [3];
  logic signed [AW-1:0] adj3_q [NL];

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      for (int j = 0; j < 3; j++) begin
        t_q[j] <= (DW'(phi_q[j]) <<< EW) + DW'(plo_q[j]);
      end
      adj3_q <= adj2_q;
    end
  end

  // ---------------- stage 4: determinant, adjugate magnitudes ----------------
  logic signed [DW-1:0] det_q;
  logic        [AW-1:0] amag4_q [NL];
  logic        [NL-1:0] aneg4_q;

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      det_q <= t_q[0] + t_q[1] + t_q[2];
      for (int k = 0; k < int'(NL); k++) begin
        amag4_q[k] <= adj3_q[k][AW-1] ? AW'(-adj3_q[k]) : AW'(adj3_q[k]);
        aneg4_q[k] <= adj3_q[k][AW-1];
      end
    end
  end

  // ---------------- stage 5: determinant magnitude ----------------
  logic [DW-1:0] dmag_q;
  logic          dneg_q;
  logic          sing_q;
  logic [AW-1:0] amag5_q [NL];
  logic [NL-1:0] aneg5_q;

  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      dmag_q  <= det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
      dneg_q  <= det_q[DW-1];
      sing_q  <= (det_q == '0);
      amag5_q <= amag4_q;
      aneg5_q <= aneg4_q;
    end
  end

  // ---------------- stage 6: range check, divider load ----------------
  localparam logic [EW-1:0] Half = EW'(1) << (EW - 1);

  logic [RW-1:0]    dlim;
  logic [RW-1:0]    num [NL];
  logic [DW-1:0]    dsh;
  logic             dfit;
  mx3i_pkg::side_t  side6_d;

  logic [RW-1:0]    rem_c  [EW+1][NL];
  logic [EW-1:0]    quo_c  [EW+1][NL];
  logic [DW-1:0]    dvs_c  [EW+1];
  mx3i_pkg::side_t  side_c [EW+1];

  always_comb begin
    dlim = RW'({dmag_q, {EW{1'b0}}});
    dsh  = dmag_q >> (2 * FRAC_BITS);
    dfit = dneg_q ? (dsh <= DW'(Half)) : (dsh < DW'(Half));
    side6_d.sing    = sing_q;
    side6_d.det_sat = !dfit;
    if (!dfit) begin
      side6_d.det_val = dneg_q ? Half : (Half - EW'(1));
    end else begin
      side6_d.det_val = dneg_q ? EW'(-dsh[EW-1:0]) : dsh[EW-1:0];
    end
    for (int k = 0; k < int'(NL); k++) begin
      num[k]            = RW'({amag5_q[k], {(2 * FRAC_BITS){1'b0}}});
      side6_d.ovf[k]    = (num[k] >= dlim);
      side6_d.neg[k]    = aneg5_q[k] ^ dneg_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[6]) begin
      for (int k = 0; k < int'(NL); k++) begin
        rem_c[0][k] <= num[k];
        quo_c[0][k] <= '0;
      end
      dvs_c[0]  <= dmag_q;
      side_c[0] <= side6_d;
    end
  end

  // ---------------- stages 7 .. 6+EW: one quotient bit each ----------------
  for (genvar j = 0; j < EW; j++) begin : g_div
    mx3i_div_step #(
      .RW    (RW),
      .DW    (DW),
      .QW    (EW),
      .SHIFT (EW - 1 - j)
    ) u_step (
      .clk_i  (clk_i),
      .ld_i   (ld[7+j]),
      .rem_i  (rem_c[j]),
      .quo_i  (quo_c[j]),
      .dvs_i  (dvs_c[j]),
      .side_i (side_c[j]),
      .rem_o  (rem_c[j+1]),
      .quo_o  (quo_c[j+1]),
      .dvs_o  (dvs_c[j+1]),
      .side_o (side_c[j+1])
    );
  end

  // ---------------- output: sign, saturate, register ----------------
  mx3i_pkg::side_t     fs;
  logic [EW-1:0]       inv_d [NL];
  logic [NL-1:0]       lsat;
  logic [EW-1:0]       qv;
  mx3i_pkg::out_word_t out_d;
  mx3i_pkg::out_word_t out_q;

  always_comb begin
    fs = side_c[EW];
    for (int k = 0; k < int'(NL); k++) begin
      qv = quo_c[EW][k];
      if (fs.sing) begin
        inv_d[k] = '0;
        lsat[k]  = 1'b0;
      end else if (fs.ovf[k] || (fs.neg[k] ? (qv > Half) : (qv >= Half))) begin
        inv_d[k] = fs.neg[k] ? Half : (Half - EW'(1));
        lsat[k]  = 1'b1;
      end else begin
        inv_d[k] = fs.neg[k] ? EW'(-qv) : qv;
        lsat[k]  = 1'b0;
      end
    end
    out_d.inv11     = inv_d[0];
    out_d.inv12     = inv_d[1];
    out_d.inv13     = inv_d[2];
    out_d.inv21     = inv_d[3];
    out_d.inv22     = inv_d[4];
    out_d.inv23     = inv_d[5];
    out_d.inv31     = inv_d[6];
    out_d.inv32     = inv_d[7];
    out_d.inv33     = inv_d[8];
    out_d.det_value = fs.det_val;
    out_d.singular  = fs.sing;
    out_d.saturated = !fs.sing && ((|lsat) || fs.det_sat);
  end

  always_ff @(posedge clk_i) begin
    if (ld[NS]) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------- checks ----------------
  `MX3I_ASSERT_IMP(a_singular_clean, out_valid_o && out_data_o.singular,
    out_data_o.inv11 == '0 && out_data_o.inv22 == '0 && out_data_o.inv33 == '0 &&
    out_data_o.det_value == '0 && !out_data_o.saturated)
  `MX3I_ASSERT_IMP(a_stall_only_blocked, !in_ready_o, out_valid_o && !out_ready_i)
  `MX3I_ASSERT_NXT(a_accept_enters, in_valid_i && in_ready_o, v_q[0])

endmodule

`default_nettype wire
